// File: hw/rtl/wsa_pkg.sv
package wsa_pkg;

    localparam int CFG_DATA_BITS  = 7;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SIZE  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLIDING_MODE = 1'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: hw/rtl/windowed_sample_averager.sv
// Moving average of signed Q8.8 samples over a window of up to WINDOW_MAX entries.
// Samples arrive on the sample channel (sample_valid, sample_ready, sample) and means
// leave on the mean channel (mean_valid, mean_ready, mean), each a valid/ready request.
// Configuration is written through cfg_we, cfg_index and cfg_data: index 0 sets the
// window size and index 1 selects sliding mode; either write restarts the averaging.
// In block mode one mean leaves for every window of samples, in sliding mode one mean
// leaves for every sample, taken over the samples gathered so far until the window fills.
// When a sample is taken the ring entry at its position is read; the update state then
// writes the ring, updates the running sum and starts a bit-serial restoring divider;
// the divide state waits for the quotient and the deliver state loads it into the
// output register, which raises mean_valid. The block takes no new sample until it is
// through with the last one, and a sample that yields no mean returns the block to idle
// straight after the update state.
// A finished mean waits in the output register while the next sample is taken; if the
// receiver still stalls when the following mean is ready, the block holds that mean
// and accepts no sample until the register frees.
// Reset sets a window of one in block mode and clears the sum, count and write position;
// the ring itself needs no clearing, as only entries written since a restart are read.
module windowed_sample_averager #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [wsa_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [wsa_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                                   sample_valid,
    output logic                                   sample_ready,
    input  logic signed [SAMPLE_BITS-1:0]          sample,
    output logic                                   mean_valid,
    input  logic                                   mean_ready,
    output logic signed [SAMPLE_BITS-1:0]          mean
);

    localparam int PW = $clog2(WINDOW_MAX);
    localparam int NW = $clog2(WINDOW_MAX + 1);
    localparam int SW = SAMPLE_BITS + $clog2(WINDOW_MAX);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DELIVER
    } state_t;

    state_t                              state_reg;
    logic [wsa_pkg::CFG_DATA_BITS-1:0]   win_size_reg;
    logic                                sliding_reg;
    logic [PW-1:0]                       wp_reg;
    logic [PW-1:0]                       pos_reg;
    logic [NW-1:0]                       fill_reg;
    logic signed [SW-1:0]                sum_reg;
    logic signed [SAMPLE_BITS-1:0]       sample_reg;
    logic                                neg_reg;
    logic                                mean_valid_reg;
    logic signed [SAMPLE_BITS-1:0]       mean_reg;

    logic [SAMPLE_BITS-1:0]              ring_mem [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0]              rd_data_reg;

    logic [NW-1:0]                       n_eff;
    logic [PW-1:0]                       pos_start;
    logic [PW-1:0]                       pos_next;
    logic signed [SW-1:0]                sample_ext;
    logic signed [SW-1:0]                old_ext;
    logic signed [SW-1:0]                sum_upd;
    logic [NW-1:0]                       fill_upd;
    logic                                emit;
    logic [NW-1:0]                       divisor;
    logic [SW-1:0]                       magnitude;
    logic                                div_start;
    logic [SW-1:0]                       div_quo;
    wsa_pkg::div_status_t                div_stat;
    logic [SW-1:0]                       result;
    logic                                sample_take;

    always_comb
    begin
        if (win_size_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (int'(win_size_reg) > WINDOW_MAX)
        begin
            n_eff = NW'(WINDOW_MAX);
        end
        else
        begin
            n_eff = NW'(win_size_reg);
        end
    end

    assign pos_start   = (NW'(wp_reg) >= n_eff) ? '0 : wp_reg;
    assign pos_next    = ((NW'(pos_reg) + NW'(1)) >= n_eff) ? '0 : pos_reg + PW'(1);
    assign sample_ext  = {{(SW - SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}}, sample_reg};
    assign old_ext     = {{(SW - SAMPLE_BITS){rd_data_reg[SAMPLE_BITS-1]}}, rd_data_reg};

    // Once the window is full in sliding mode, the oldest sample leaves the running sum.
    always_comb
    begin
        sum_upd  = sum_reg + sample_ext;
        fill_upd = fill_reg + NW'(1);
        if (sliding_reg && (fill_reg >= n_eff))
        begin
            sum_upd  = sum_reg + sample_ext - old_ext;
            fill_upd = fill_reg;
        end
        emit      = sliding_reg || (fill_upd >= n_eff);
        divisor   = sliding_reg ? fill_upd : n_eff;
        if (divisor == '0)
        begin
            divisor = NW'(1);
        end
        magnitude = sum_upd[SW-1] ? SW'(-sum_upd) : SW'(sum_upd);
    end

    assign sample_ready = (state_reg == ST_IDLE) && !cfg_we;
    assign sample_take  = sample_valid && sample_ready;
    assign div_start    = (state_reg == ST_UPDATE) && emit;
    assign result       = neg_reg ? SW'(-div_quo) : div_quo;

    wsa_divider #(
        .DIVIDEND_BITS (SW),
        .DIVISOR_BITS  (NW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (magnitude),
        .divisor  (divisor),
        .quotient (div_quo),
        .status   (div_stat)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPDATE)
        begin
            ring_mem[pos_reg] <= sample_reg;
        end
        rd_data_reg <= ring_mem[pos_start];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            win_size_reg   <= wsa_pkg::CFG_DATA_BITS'(1);
            sliding_reg    <= 1'b0;
            wp_reg         <= '0;
            pos_reg        <= '0;
            fill_reg       <= '0;
            sum_reg        <= '0;
            sample_reg     <= '0;
            neg_reg        <= 1'b0;
            mean_valid_reg <= 1'b0;
            mean_reg       <= '0;
        end
        else
        begin
            if (mean_valid_reg && mean_ready && (state_reg != ST_DELIVER))
            begin
                mean_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_we)
                    begin
                        if (cfg_index == wsa_pkg::REG_WINDOW_SIZE)
                        begin
                            win_size_reg <= cfg_data;
                        end
                        else
                        begin
                            sliding_reg <= cfg_data[0];
                        end
                        wp_reg   <= '0;
                        fill_reg <= '0;
                        sum_reg  <= '0;
                    end
                    else if (sample_take)
                    begin
                        sample_reg <= sample;
                        pos_reg    <= pos_start;
                        state_reg  <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    wp_reg <= pos_next;
                    if (emit)
                    begin
                        neg_reg   <= sum_upd[SW-1];
                        state_reg <= ST_DIVIDE;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                    if (emit && !sliding_reg)
                    begin
                        sum_reg  <= '0;
                        fill_reg <= '0;
                    end
                    else
                    begin
                        sum_reg  <= sum_upd;
                        fill_reg <= fill_upd;
                    end
                end
                ST_DIVIDE:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= ST_DELIVER;
                    end
                end
                ST_DELIVER:
                begin
                    if (!mean_valid_reg || mean_ready)
                    begin
                        mean_reg       <= result[SAMPLE_BITS-1:0];
                        mean_valid_reg <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign mean_valid = mean_valid_reg;
    assign mean       = mean_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("Divider started while still busy.");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIVIDE))
        else $error("Divider finished outside the divide phase.");

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= n_eff)
        else $error("Sample count exceeds the window size.");

    assert property (@(posedge clk) disable iff (!rst_n)
        NW'(wp_reg) < n_eff)
        else $error("Write position lies outside the window.");

endmodule

// File: hw/rtl/wsa_divider.sv
module wsa_divider #(
    parameter int DIVIDEND_BITS = 22,
    parameter int DIVISOR_BITS  = 7
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic [DIVIDEND_BITS-1:0] quotient,
    output wsa_pkg::div_status_t     status
);

    localparam int COUNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  div_reg;
    logic [COUNT_BITS-1:0]    count_reg;
    logic                     busy_reg;
    logic                     done_reg;

    logic [DIVISOR_BITS:0]    trial;
    logic                     fits;
    logic [DIVISOR_BITS-1:0]  rem_next;

    // One quotient bit is settled per cycle by a restoring step.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        fits     = (trial >= {1'b0, div_reg});
        rem_next = fits ? DIVISOR_BITS'(trial - {1'b0, div_reg}) : trial[DIVISOR_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= COUNT_BITS'(DIVIDEND_BITS);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - COUNT_BITS'(1);
                if (count_reg == COUNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
